FILE: design/phd_pkg.sv
package phd_pkg;

	// header layout, byte offsets within the buffer
	localparam logic [3:0] HEADER_BYTES   = 4'd11;
	localparam logic [3:0] VERSION_OFFSET = 4'd4;
	localparam logic [3:0] COMMAND_OFFSET = 4'd6;
	localparam logic [3:0] LENGTH_OFFSET  = 4'd7;

	// configuration port
	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W  = 32;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_MAGIC   = 4'd0,
		REG_VERSION = 4'd1
	} reg_index_t;

	typedef enum logic [2:0] {
		ST_OK            = 3'd0,
		ST_HEADER_SHORT  = 3'd1,
		ST_BAD_MAGIC     = 3'd2,
		ST_BAD_VERSION   = 3'd3,
		ST_PAYLOAD_SHORT = 3'd4
	} status_t;

	typedef struct packed {
		logic [31:0] magic_value;
		logic [15:0] version_value;
	} cfg_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_buffer;
	} in_item_t;

	typedef struct packed {
		logic        payload_valid;
		logic [7:0]  payload_byte;
		logic        frame_done;
		status_t     status;
		logic [7:0]  command_out;
		logic [31:0] payload_length;
	} result_t;

endpackage

FILE: design/phd_in_if.sv
interface phd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_buffer;

	modport source (output valid, output in_byte, output end_of_buffer, input ready);
	modport sink (input valid, input in_byte, input end_of_buffer, output ready);
endinterface

FILE: design/phd_out_if.sv
interface phd_out_if;
	logic        valid;
	logic        ready;
	logic        payload_valid;
	logic [7:0]  payload_byte;
	logic        frame_done;
	logic [2:0]  status;
	logic [7:0]  command_out;
	logic [31:0] payload_length;

	modport source (output valid, output payload_valid, output payload_byte,
		output frame_done, output status, output command_out,
		output payload_length, input ready);
	modport sink (input valid, input payload_valid, input payload_byte,
		input frame_done, input status, input command_out,
		input payload_length, output ready);
endinterface

FILE: design/phd_cfg_if.sv
interface phd_cfg_if;
	logic        valid;
	logic        ready;
	logic [3:0]  index;
	logic [31:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: design/phd_cfg_regs.sv
module phd_cfg_regs (
	input  logic         clk,
	input  logic         arst_n,
	phd_cfg_if.sink      cfg,
	output phd_pkg::cfg_t regs
);
	import phd_pkg::*;

	logic [31:0] magic_q;
	logic [15:0] version_q;

	// writes are always taken, unknown indexes are dropped
	assign cfg.ready = 1'b1;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q   <= '0;
			version_q <= '0;
		end else if (cfg.valid) begin
			if (cfg.index == REG_MAGIC) begin
				magic_q <= cfg.data;
			end else if (cfg.index == REG_VERSION) begin
				version_q <= cfg.data[15:0];
			end
		end
	end

	assign regs.magic_value   = magic_q;
	assign regs.version_value = version_q;

endmodule

FILE: design/phd_parse.sv
module phd_parse (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  phd_pkg::in_item_t item,
	input  phd_pkg::cfg_t     regs,
	output phd_pkg::result_t  res
);
	import phd_pkg::*;

	logic [3:0]  pos_q, pos_n;
	logic        magic_bad_q, magic_bad_n;
	logic        ver_bad_q, ver_bad_n;
	logic [7:0]  cmd_q, cmd_n;
	logic [31:0] len_q, len_n;
	logic [31:0] rem_q, rem_n;
	logic [1:0]  len_sel;
	status_t     status;

	// length byte lane: offsets 7..10 map to lanes 0..3
	assign len_sel = pos_q[1:0] + 2'd1;

	// header capture, payload count and status for the current byte
	always_comb begin
		pos_n       = pos_q;
		magic_bad_n = magic_bad_q;
		ver_bad_n   = ver_bad_q;
		cmd_n       = cmd_q;
		len_n       = len_q;
		rem_n       = rem_q;
		res         = '0;
		res.frame_done = item.end_of_buffer;

		if (pos_q < HEADER_BYTES) begin
			priority if (pos_q < VERSION_OFFSET) begin
				if (regs.magic_value[{pos_q[1:0], 3'b000} +: 8] != item.in_byte) begin
					magic_bad_n = 1'b1;
				end
			end else if (pos_q < COMMAND_OFFSET) begin
				if (regs.version_value[{pos_q[0], 3'b000} +: 8] != item.in_byte) begin
					ver_bad_n = 1'b1;
				end
			end else if (pos_q == COMMAND_OFFSET) begin
				cmd_n = item.in_byte;
			end else begin
				len_n = len_q | ({24'd0, item.in_byte} << {len_sel, 3'b000});
			end
			pos_n = pos_q + 4'd1;
			if (pos_n == HEADER_BYTES) begin
				rem_n = len_n;
			end
		end else if (rem_q != 32'd0) begin
			if (!magic_bad_q && !ver_bad_q) begin
				res.payload_valid = 1'b1;
				res.payload_byte  = item.in_byte;
			end
			rem_n = rem_q - 32'd1;
		end

		// error order: header, magic, version, payload
		priority if (pos_n < HEADER_BYTES) begin
			status = ST_HEADER_SHORT;
		end else if (magic_bad_n) begin
			status = ST_BAD_MAGIC;
		end else if (ver_bad_n) begin
			status = ST_BAD_VERSION;
		end else if (rem_n != 32'd0) begin
			status = ST_PAYLOAD_SHORT;
		end else begin
			status = ST_OK;
		end

		// last byte reports and clears the frame state
		if (item.end_of_buffer) begin
			res.status = status;
			if (status == ST_OK) begin
				res.command_out    = cmd_n;
				res.payload_length = len_n;
			end
			pos_n       = '0;
			magic_bad_n = 1'b0;
			ver_bad_n   = 1'b0;
			cmd_n       = '0;
			len_n       = '0;
			rem_n       = '0;
		end
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			magic_bad_q <= 1'b0;
			ver_bad_q   <= 1'b0;
			cmd_q       <= '0;
			len_q       <= '0;
			rem_q       <= '0;
		end else if (step) begin
			pos_q       <= pos_n;
			magic_bad_q <= magic_bad_n;
			ver_bad_q   <= ver_bad_n;
			cmd_q       <= cmd_n;
			len_q       <= len_n;
			rem_q       <= rem_n;
		end
	end

	// checks
	a_clear_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.end_of_buffer |=> pos_q == 4'd0 && rem_q == 32'd0)
		else $error("frame state not cleared after last byte");

	a_status_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		!item.end_of_buffer |-> res.status == ST_OK && res.payload_length == 32'd0)
		else $error("status reported before last byte");

	a_payload_after_header: assert property (@(posedge clk) disable iff (!arst_n)
		res.payload_valid |-> pos_q == HEADER_BYTES && !magic_bad_q && !ver_bad_q)
		else $error("payload passed before header checked");

	a_pos_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= HEADER_BYTES)
		else $error("header position beyond header");

endmodule

FILE: design/packet_header_deframer.sv
// channel  | role | payload                                    | accepted when
// ---------+------+--------------------------------------------+-------------------
// in_ch    | sink | in_byte, end_of_buffer                     | valid && ready
// out_ch   | src  | payload_valid/byte, frame_done, status,    | valid && ready
//          |      | command_out, payload_length                |
// cfg      | sink | index (0 magic, 1 version), data           | valid (ready tied)
//
// one byte a cycle sustained while out_ch.ready is high; input register then result register
// the rate is set by the single pass from the input register to the result register
// all frame state and the configuration registers clear on arst_n
// a stalled output holds its result while the input register, if empty, takes one more byte
// in_ch.ready follows out_ch.ready through the two pipeline stages
module packet_header_deframer (
	input  logic      clk,
	input  logic      arst_n,
	phd_in_if.sink    in_ch,
	phd_out_if.source out_ch,
	phd_cfg_if.sink   cfg
);
	import phd_pkg::*;

	cfg_t     regs;
	in_item_t item_s1;
	logic     valid_s1;
	result_t  res;
	result_t  res_s2;
	logic     valid_s2;
	logic     adv_s1;
	logic     in_take;

	// pipeline flow control
	assign adv_s1      = valid_s1 && (!valid_s2 || out_ch.ready);
	assign in_ch.ready = !valid_s1 || adv_s1;
	assign in_take     = in_ch.valid && in_ch.ready;

	phd_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.in_byte       <= in_ch.in_byte;
			item_s1.end_of_buffer <= in_ch.end_of_buffer;
		end
	end

	phd_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv_s1),
		.item   (item_s1),
		.regs   (regs),
		.res    (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ch.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res;
		end
	end

	assign out_ch.valid          = valid_s2;
	assign out_ch.payload_valid  = res_s2.payload_valid;
	assign out_ch.payload_byte   = res_s2.payload_byte;
	assign out_ch.frame_done     = res_s2.frame_done;
	assign out_ch.status         = res_s2.status;
	assign out_ch.command_out    = res_s2.command_out;
	assign out_ch.payload_length = res_s2.payload_length;

endmodule

FILE: tb/sv/packet_header_deframer_test.sv
module packet_header_deframer_test;
	import phd_pkg::*;

	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int SETTLE_CYCLES   = 8;
	localparam int IDLE_PERCENT    = 15;
	localparam int HOLD_OFF_CYCLES = 120;
	localparam int MAX_REPORTS     = 64;
	localparam logic [CFG_INDEX_W-1:0] UNMAPPED_INDEX = '1;

	typedef logic [7:0] byte_q_t[$];

	typedef enum int {
		FR_GOOD,
		FR_TRAILING,
		FR_PAYLOAD_SHORT,
		FR_HUGE_LENGTH,
		FR_BAD_MAGIC,
		FR_BAD_VERSION,
		FR_HEADER_SHORT,
		FR_NOISE
	} frame_kind_t;

	logic clk;
	logic arst_n;

	phd_in_if  in_ch();
	phd_out_if out_ch();
	phd_cfg_if cfg();

	packet_header_deframer u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg)
	);

	// deframer state as the testbench tracks it
	logic [31:0] magic_reg     = '0;
	logic [15:0] version_reg   = '0;
	logic [3:0]  hdr_seen      = '0;
	logic        magic_wrong   = 1'b0;
	logic        version_wrong = 1'b0;
	logic [7:0]  cmd_kept      = '0;
	logic [31:0] len_kept      = '0;
	logic [31:0] payload_left  = '0;

	result_t deframed_due[$];

	int  mismatch_count = 0;
	int  items_sent     = 0;
	int  quiet_cycles   = 0;
	int  hold_left      = 0;
	bit  hold_armed     = 1'b0;
	bit  hold_started   = 1'b0;
	bit  steady_flow    = 1'b0;

	// clock
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// expected result for one byte, advancing the tracked frame state
	function automatic result_t deframe_byte(input logic [7:0] b, input logic eob);
		result_t r;
		int pos;
		r = '0;
		r.status = ST_OK;
		pos = int'(hdr_seen);
		if (hdr_seen < HEADER_BYTES) begin
			// header byte: compare magic and version, capture command and length
			if (hdr_seen < VERSION_OFFSET) begin
				if (magic_reg[8*pos +: 8] != b) magic_wrong = 1'b1;
			end else if (hdr_seen < COMMAND_OFFSET) begin
				if (version_reg[8*(pos - int'(VERSION_OFFSET)) +: 8] != b)
					version_wrong = 1'b1;
			end else if (hdr_seen == COMMAND_OFFSET) begin
				cmd_kept = b;
			end else begin
				len_kept[8*(pos - int'(LENGTH_OFFSET)) +: 8] = b;
			end
			hdr_seen = hdr_seen + 4'd1;
			if (hdr_seen == HEADER_BYTES) payload_left = len_kept;
		end else if (payload_left != 0) begin
			// payload byte, held back once the header is known bad
			if (!magic_wrong && !version_wrong) begin
				r.payload_valid = 1'b1;
				r.payload_byte  = b;
			end
			payload_left = payload_left - 32'd1;
		end
		if (eob) begin
			r.frame_done = 1'b1;
			if (hdr_seen < HEADER_BYTES)
				r.status = ST_HEADER_SHORT;
			else if (magic_wrong)
				r.status = ST_BAD_MAGIC;
			else if (version_wrong)
				r.status = ST_BAD_VERSION;
			else if (payload_left != 0)
				r.status = ST_PAYLOAD_SHORT;
			if (r.status == ST_OK) begin
				r.command_out    = cmd_kept;
				r.payload_length = len_kept;
			end
			hdr_seen      = '0;
			magic_wrong   = 1'b0;
			version_wrong = 1'b0;
			cmd_kept      = '0;
			len_kept      = '0;
			payload_left  = '0;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		if (mismatch_count < MAX_REPORTS)
			$display("mismatch %s: got %0h want %0h", what, got, want);
		mismatch_count++;
	endtask

	// predict on every accepted input transaction
	always @(posedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready)
			deframed_due = {deframed_due, deframe_byte(in_ch.in_byte, in_ch.end_of_buffer)};
	end

	// compare each accepted output transaction with the oldest prediction
	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (deframed_due.size() == 0) begin
				report_mismatch("result with nothing due", 32'(out_ch.status), 32'd0);
			end else begin
				want = deframed_due.pop_front();
				if (out_ch.payload_valid !== want.payload_valid)
					report_mismatch("payload_valid", 32'(out_ch.payload_valid),
						32'(want.payload_valid));
				if (out_ch.payload_byte !== want.payload_byte)
					report_mismatch("payload_byte", 32'(out_ch.payload_byte),
						32'(want.payload_byte));
				if (out_ch.frame_done !== want.frame_done)
					report_mismatch("frame_done", 32'(out_ch.frame_done),
						32'(want.frame_done));
				if (out_ch.status !== want.status)
					report_mismatch("status", 32'(out_ch.status), 32'(want.status));
				if (out_ch.command_out !== want.command_out)
					report_mismatch("command_out", 32'(out_ch.command_out),
						32'(want.command_out));
				if (out_ch.payload_length !== want.payload_length)
					report_mismatch("payload_length", out_ch.payload_length,
						want.payload_length);
			end
		end
	end

	// receiver: random stalls, steady stretches and one long hold-off
	always @(posedge clk) begin
		if (hold_armed && !hold_started) begin
			hold_started = 1'b1;
			hold_left = HOLD_OFF_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ch.ready <= 1'b0;
		end else if (steady_flow) begin
			out_ch.ready <= 1'b1;
		end else begin
			out_ch.ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
		end
	end

	// watchdog on cycles with no transaction on any channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
				(cfg.valid && cfg.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	// one configuration transaction; valid stays high for a following write
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value, input bit last_write);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= value;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		if (idx == REG_MAGIC)
			magic_reg = value;
		else if (idx == REG_VERSION)
			version_reg = value[15:0];
		if (last_write) cfg.valid <= 1'b0;
	endtask

	// one input transaction, with random idle cycles ahead of it unless steady_flow is set
	task automatic send_byte(input logic [7:0] b, input logic eob);
		if (!steady_flow) begin
			while ($urandom_range(0, 99) < IDLE_PERCENT) begin
				in_ch.valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_ch.valid         <= 1'b1;
		in_ch.in_byte       <= b;
		in_ch.end_of_buffer <= eob;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		items_sent++;
	endtask

	task automatic send_buffer(input byte_q_t frame);
		for (int i = 0; i < frame.size(); i++)
			send_byte(frame[i], i == frame.size() - 1);
	endtask

	// let every outstanding result come back before touching the registers
	// the prediction for the last accepted byte is queued before the queue is checked
	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (deframed_due.size() != 0) @(posedge clk);
	endtask

	function automatic byte_q_t make_header(input logic [31:0] magic, input logic [15:0] ver,
		input logic [7:0] cmd, input logic [31:0] len);
		byte_q_t hdr;
		hdr = {};
		for (int i = 0; i < 4; i++) hdr = {hdr, magic[8*i +: 8]};
		for (int i = 0; i < 2; i++) hdr = {hdr, ver[8*i +: 8]};
		hdr = {hdr, cmd};
		for (int i = 0; i < 4; i++) hdr = {hdr, len[8*i +: 8]};
		return hdr;
	endfunction

	function automatic frame_kind_t pick_frame_kind();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30) return FR_GOOD;
		if (r < 45) return FR_TRAILING;
		if (r < 58) return FR_PAYLOAD_SHORT;
		if (r < 66) return FR_HUGE_LENGTH;
		if (r < 74) return FR_BAD_MAGIC;
		if (r < 82) return FR_BAD_VERSION;
		if (r < 92) return FR_HEADER_SHORT;
		return FR_NOISE;
	endfunction

	// build one buffer of the given kind from the current register values
	task automatic send_frame(input frame_kind_t kind);
		byte_q_t frame;
		logic [31:0] magic;
		logic [15:0] ver;
		logic [31:0] len;
		int body;
		int keep;
		int pos;
		magic = magic_reg;
		ver   = version_reg;
		len   = 32'($urandom_range(0, 8));
		body  = int'(len);
		pos   = $urandom_range(0, 3);
		case (kind)
			FR_TRAILING: begin
				body = int'(len) + $urandom_range(1, 5);
			end
			FR_PAYLOAD_SHORT: begin
				len  = 32'($urandom_range(1, 8));
				body = $urandom_range(0, int'(len) - 1);
			end
			FR_HUGE_LENGTH: begin
				len  = $urandom() | 32'h0000_0100;
				body = $urandom_range(0, 8);
			end
			FR_BAD_MAGIC: begin
				magic[8*pos +: 8] ^= 8'($urandom_range(1, 255));
				if ($urandom_range(0, 1)) ver ^= 16'($urandom_range(1, 65535));
				body = $urandom_range(0, int'(len) + 3);
			end
			FR_BAD_VERSION: begin
				ver[8*(pos % 2) +: 8] ^= 8'($urandom_range(1, 255));
				body = $urandom_range(0, int'(len) + 3);
			end
			FR_HEADER_SHORT: begin
				if ($urandom_range(0, 1)) magic[8*pos +: 8] ^= 8'($urandom_range(1, 255));
			end
			default: ;
		endcase
		if (kind == FR_NOISE) begin
			frame = {};
			body = $urandom_range(1, 16);
		end else begin
			frame = make_header(magic, ver, 8'($urandom()), len);
		end
		if (kind == FR_HEADER_SHORT) begin
			keep = $urandom_range(1, 10);
			while (frame.size() > keep) void'(frame.pop_back());
			body = 0;
		end
		repeat (body) frame = {frame, 8'($urandom())};
		send_buffer(frame);
	endtask

	task automatic run_random_frames(input int n_items);
		int start;
		start = items_sent;
		while (items_sent - start < n_items) send_frame(pick_frame_kind());
	endtask

	// short buffers covering byte extremes, error order and payload on the last byte
	task automatic test_directed();
		byte_q_t frame;
		write_reg(REG_MAGIC, 32'hFF00_5AA5, 1'b0);
		write_reg(REG_VERSION, 32'h0000_00FF, 1'b1);
		// lone byte ending the buffer
		frame = {8'h00};
		send_buffer(frame);
		// good header, single payload byte that also ends the buffer
		frame = make_header(32'hFF00_5AA5, 16'h00FF, 8'hFF, 32'd1);
		frame = {frame, 8'hFF};
		send_buffer(frame);
		// magic and version both wrong: magic wins, payload held back
		frame = make_header(32'h00FF_A55A, 16'hFF00, 8'h00, 32'd1);
		frame = {frame, 8'h00};
		send_buffer(frame);
		wait_drained();
	endtask

	// all-zero and all-one register settings, plus writes to unmapped indexes
	task automatic test_register_extremes();
		write_reg(REG_MAGIC, 32'h0000_0000, 1'b0);
		write_reg(REG_VERSION, 32'hFFFF_0000, 1'b0);
		write_reg(UNMAPPED_INDEX, 32'hFFFF_FFFF, 1'b1);
		steady_flow = 1'b1;
		run_random_frames(130);
		wait_drained();
		steady_flow = 1'b0;
		write_reg(REG_MAGIC, 32'hFFFF_FFFF, 1'b0);
		write_reg(REG_VERSION, 32'h0000_FFFF, 1'b0);
		write_reg(4'($urandom_range(int'(REG_VERSION) + 1, int'(UNMAPPED_INDEX))),
			$urandom(), 1'b1);
		run_random_frames(130);
		wait_drained();
	endtask

	task automatic test_random_settings();
		repeat (2) begin
			write_reg(REG_MAGIC, $urandom(), 1'b0);
			write_reg(REG_VERSION, $urandom(), 1'b1);
			run_random_frames(100);
			wait_drained();
		end
	endtask

	// receiver holds off while the sender keeps offering bytes
	task automatic test_backpressure();
		steady_flow = 1'b1;
		hold_armed  = 1'b1;
		run_random_frames(60);
		wait_drained();
		steady_flow = 1'b0;
	endtask

	initial begin
		arst_n              = 1'b0;
		in_ch.valid         = 1'b0;
		in_ch.in_byte       = '0;
		in_ch.end_of_buffer = 1'b0;
		cfg.valid           = 1'b0;
		cfg.index           = '0;
		cfg.data            = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_register_extremes();
		test_random_settings();
		test_backpressure();

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (deframed_due.size() != 0)
			report_mismatch("results never delivered", 32'(deframed_due.size()), 32'd0);
		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

FILE: packet_header_deframer.f
design/phd_pkg.sv
design/phd_in_if.sv
design/phd_out_if.sv
design/phd_cfg_if.sv
design/phd_cfg_regs.sv
design/phd_parse.sv
design/packet_header_deframer.sv
tb/sv/packet_header_deframer_test.sv
